[rtl/core/swm_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum: shared definitions
// Register width and reset value of the window size setting.
// ----------------------------------------------------------------------------
package swm_pkg;

  // window size register
  localparam int unsigned CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd1;

endpackage

[rtl/core/sliding_window_minimum.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum
// Minimum of the last window_size signed samples, by a chain of min cells.
// ----------------------------------------------------------------------------
// Takes one sample per clock when the output side keeps up; the result of a
// sample appears in the output register in the cycle after it is accepted and
// the input stalls only while a result waits there. The cycle is set by one
// signed compare in each cell followed by the window-size select across the
// MAX_WINDOW cells. Cell k holds the minimum of the last k+1 samples, so a
// window of size w reads cell w-1. The first window_size-1 samples after a
// restart produce no output word; the window size applies at once when
// changed, and 0 is taken as 1, values above MAX_WINDOW as MAX_WINDOW.
module sliding_window_minimum #(
  parameter int unsigned MAX_WINDOW   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample
  input  logic                                   s_axis_tuser,  // restart
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // window_min
  // window size register
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [swm_pkg::CFG_WIDTH-1:0]          cfg_data       // window_size
);

  localparam int unsigned TDW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned IDXW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FCW  = $clog2(MAX_WINDOW + 1);

  logic [swm_pkg::CFG_WIDTH-1:0]  win_q;
  logic [FCW-1:0]                 win_eff;
  logic [FCW-1:0]                 fill_q, fill_d;
  logic [IDXW-1:0]                sel;
  logic                           in_acc;
  logic                           restart;
  logic                           hit;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [SAMPLE_WIDTH-1:0] cell_d [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cell_q [MAX_WINDOW];
  logic                           out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0]        out_data_q;

  // window size register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= swm_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      win_q <= cfg_data;
    end
  end

  // clamp to 1..MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      win_eff = FCW'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      win_eff = FCW'(MAX_WINDOW);
    end else begin
      win_eff = FCW'(win_q);
    end
  end

  // input handshake
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign restart       = s_axis_tuser;

  // samples held in this sequence, saturating
  always_comb begin
    if (restart) begin
      fill_d = FCW'(1);
    end else if (32'(fill_q) < MAX_WINDOW) begin
      fill_d = fill_q + FCW'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_acc) begin
      fill_q <= fill_d;
    end
  end

  // cell chain; cell 0 just loads the sample
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (in_acc),
      .sample_i(sample),
      .prev_i  ((k == 0) ? sample : cell_q[(k == 0) ? 0 : k - 1]),
      .min_d_o (cell_d[k]),
      .min_q_o (cell_q[k])
    );
  end

  // pick the cell that spans the window
  assign hit = (fill_d >= win_eff);
  assign sel = IDXW'(win_eff - FCW'(1));

  // output register
  always_comb begin
    if (in_acc) begin
      out_valid_d = hit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && hit) begin
      out_data_q <= cell_d[sel];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'(out_data_q);

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MAX_WINDOW)
    else $error("fill count above window depth");

  a_restart_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && restart && (win_eff != FCW'(1)) |=> !m_axis_tvalid)
    else $error("result after restart with window above one");

  a_unit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (win_eff == FCW'(1)) |=>
      m_axis_tvalid && (m_axis_tdata[SAMPLE_WIDTH-1:0] == $past(sample)))
    else $error("window of one does not pass the sample");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc && m_axis_tready |=> !m_axis_tvalid)
    else $error("result without accepted word");

endmodule

[rtl/core/swm_cell.sv]
// ----------------------------------------------------------------------------
// Sliding window minimum: chain cell
// Cell k holds the minimum of the last k+1 samples. On each accepted word it
// takes the minimum of its left neighbor's value and the incoming sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,      // word accepted
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,  // incoming sample
  input  logic signed [SAMPLE_WIDTH-1:0] prev_i,    // left neighbor, old value
  output logic signed [SAMPLE_WIDTH-1:0] min_d_o,   // value after this word
  output logic signed [SAMPLE_WIDTH-1:0] min_q_o    // held value
);

  logic signed [SAMPLE_WIDTH-1:0] min_q;

  // running minimum, one compare
  assign min_d_o = (prev_i < sample_i) ? prev_i : sample_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      min_q <= min_d_o;
    end
  end

  assign min_q_o = min_q;

endmodule
